// File: rtl/core/assert_macros.svh
// Assertion helper macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same check, also active during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/core/kmth_pkg.sv
// Package with shared types and constants for the tap-hold engine
`timescale 1ns / 1ps
`default_nettype none
package kmth_pkg;
   localparam int NumRowsDef = 4;
   localparam int NumColsDef = 4;
   localparam int SeqLenDef  = 8;
   localparam int MaxRes     = 8;
   localparam int NumKeysMax = 16;

   localparam logic [7:0] EMPTY_SLOT = 8'hff;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PRESSED  = 3'd1;
   localparam logic [2:0] ST_RELEASED = 3'd2;
   localparam logic [2:0] ST_LONG     = 3'd3;
   localparam logic [2:0] ST_TAPDANCE = 3'd4;

   localparam logic [1:0] LP_IDLE = 2'd0;
   localparam logic [1:0] LP_WAIT = 2'd1;
   localparam logic [1:0] LP_HELD = 2'd2;

   localparam logic [2:0] EV_PRESS        = 3'd0;
   localparam logic [2:0] EV_RELEASE      = 3'd1;
   localparam logic [2:0] EV_LONG_TIMEOUT = 3'd2;
   localparam logic [2:0] EV_MT_SHORT     = 3'd3;
   localparam logic [2:0] EV_TAP_DANCE    = 3'd4;
   localparam logic [2:0] EV_MT_LONG      = 3'd5;
   localparam logic [2:0] EV_LEADER       = 3'd6;

   localparam logic [2:0] CSR_MODE_SELECT = 3'd0;
   localparam logic [2:0] CSR_KEY_MODES   = 3'd1;
   localparam logic [2:0] CSR_LONG_PRESS  = 3'd2;
   localparam logic [2:0] CSR_TAP_INTV    = 3'd3;
   localparam logic [2:0] CSR_DEBOUNCE    = 3'd4;

   localparam logic [15:0] LONG_PRESS_RST = 16'd600;
   localparam logic [15:0] TAP_INTV_RST   = 16'd600;
   localparam logic [7:0]  DEBOUNCE_RST   = 8'd20;

   typedef struct packed {
      logic        func;
      logic [3:0]  key_index;
      logic        key_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  key_index_out;
      logic [31:0] held_ms;
      logic [7:0]  tap_count;
      logic [7:0]  seq_key;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/core/key_matrix_tap_hold_engine.sv
// Top level of the key matrix tap/hold event engine
// Usage:
//  req channel: one word per scan-start tick (func 0) or key level sample (func 1),
//  each stamped with now_ms. rsp channel: event words; a leader run is up to
//  eight words with last set on the final one, key events are single words.
//  csr port: plain writes, only while the engine is idle.
// Timing: a key event word goes through the input register, then one update pass
//  writes it into the result queue; a leader run first goes into the burst
//  snapshot and then gives one word per cycle into the queue.
// Throughput: one req word per cycle while req is not stalled; req is stalled while a
//  leader run is being written into the queue (from the firing tick to the last word).
// The result queue holds 16 words; req is stalled while fewer than nine slots
//  are free (one word from the pass in flight plus a full run from the word
//  being taken), so a stalled rsp side backs up into req without losing words.
// Reset (synchronous): all keys idle, levels low, leader machine idle and armed,
//  registers back to mode 0, no key flags, 600/600 ms intervals, 20 ms debounce.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module key_matrix_tap_hold_engine
   import kmth_pkg::*;
#(
   parameter int NUM_ROWS = NumRowsDef,
   parameter int NUM_COLS = NumColsDef,
   parameter int SEQ_LEN  = SeqLenDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_word,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   localparam int NKEYS  = NUM_ROWS * NUM_COLS;
   localparam int NOUT   = (SEQ_LEN < MaxRes) ? SEQ_LEN : MaxRes;
   localparam int QDEPTH = 16;
   localparam int SW     = $clog2(SEQ_LEN);
   localparam int LSW    = (SW < 1) ? 1 : SW;
   localparam int QCW    = $clog2(QDEPTH+1);
   localparam int LIW    = (NOUT > 1) ? $clog2(NOUT) : 1;

   // configuration
   logic        mode_ff;
   logic [63:0] kmodes_ff;
   logic [15:0] lp_ms_ff, tap_ms_ff;
   logic [7:0]  db_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         kmodes_ff <= '0;
         lp_ms_ff  <= LONG_PRESS_RST;
         tap_ms_ff <= TAP_INTV_RST;
         db_ms_ff  <= DEBOUNCE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE_SELECT: mode_ff   <= csr_wdata[0];
            CSR_KEY_MODES:   kmodes_ff <= csr_wdata;
            CSR_LONG_PRESS:  lp_ms_ff  <= csr_wdata[15:0];
            CSR_TAP_INTV:    tap_ms_ff <= csr_wdata[15:0];
            CSR_DEBOUNCE:    db_ms_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   logic    iv_ff;
   req_type ir_ff;
   logic    req_take;
   logic [QCW-1:0] free_cnt;

   // per-pass scratch
   logic [3:0]  k;
   logic        kok;
   logic [2:0]  st, st_in;
   logic        plev_in, dba_in, pt_we, mt_we, seq_we, seq_clr;
   logic [3:0]  modes;
   logic        raw_off, td, mt, lsimple, normal, lev;
   logic [31:0] now, held, dm;
   logic        ev1;
   rsp_type     ev_word;
   logic        lead_fire;
   logic [LIW-1:0] lead_idx_ff;
   logic        lead_busy_ff;
   logic        push;
   rsp_type     push_word;

   // room for one word from the pass in flight plus a full run from the word taken;
   // hold off while a leader run is going into the queue
   assign req_stall = (free_cnt < QCW'(NOUT + 1)) || lead_fire || lead_busy_ff;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_take) ir_ff <= req_word;
      if (reset) iv_ff <= 1'b0;
      else       iv_ff <= req_take;
   end

   // key state
   logic [2:0]  pst_ff  [NKEYS];
   logic        plev_ff [NKEYS];
   logic        dba_ff  [NKEYS];
   logic [31:0] ptime_ff[NKEYS];
   logic [31:0] mtime_ff[NKEYS];
   logic [7:0]  taps_ff, taps_in;
   logic [1:0]  lph_ff, lph_in;
   logic [31:0] ltim_ff, ltim_in;
   logic [7:0]  lseq_ff [SEQ_LEN];
   logic [7:0]  lcnt_ff, lcnt_in;
   logic        lkd_ff, lkd_in, larm_ff, larm_in;

   always_comb begin
      k       = ir_ff.key_index;
      kok     = (32'(k) < NKEYS);
      lev     = ir_ff.key_level;
      now     = ir_ff.now_ms;
      st      = pst_ff[k];
      st_in   = st;
      plev_in = plev_ff[k];
      dba_in  = dba_ff[k];
      pt_we   = 1'b0;
      mt_we   = 1'b0;
      seq_we  = 1'b0;
      seq_clr = 1'b0;
      modes   = kmodes_ff[{k, 2'b00} +: 4];
      raw_off = modes[0];
      td      = modes[1];
      mt      = modes[2];
      lsimple = modes[3];
      normal  = !mode_ff;
      held    = now - ptime_ff[k];
      dm      = now - mtime_ff[k];
      taps_in = taps_ff;
      lph_in  = lph_ff;
      ltim_in = ltim_ff;
      lcnt_in = lcnt_ff;
      lkd_in  = lkd_ff;
      larm_in = larm_ff;
      ev1     = 1'b0;
      lead_fire = 1'b0;
      ev_word = '{event_kind: EV_PRESS, key_index_out: k, held_ms: held,
                  tap_count: taps_ff, seq_key: EMPTY_SLOT, last: 1'b1};

      if (iv_ff && !ir_ff.func) begin
         if (mode_ff && larm_ff) begin
            case (lph_ff)
               LP_WAIT: begin
                  if (lkd_ff) lph_in = LP_HELD;
                  else if ((now - ltim_ff) > {16'd0, tap_ms_ff}) begin
                     lead_fire = 1'b1;
                     larm_in   = 1'b0;
                     lph_in    = LP_IDLE;
                  end
               end
               LP_HELD: begin
                  if (!lkd_ff) begin
                     if (lcnt_ff != 8'hff) lcnt_in = lcnt_ff + 8'd1;
                     ltim_in = now;
                     lph_in  = LP_WAIT;
                  end
               end
               default: begin
                  ltim_in = now;
                  lph_in  = LP_WAIT;
                  seq_clr = 1'b1;
                  lcnt_in = '0;
                  lkd_in  = 1'b0;
               end
            endcase
         end else if (!mode_ff) begin
            larm_in = 1'b1;
         end
      end else if (iv_ff && kok) begin
         if (plev_ff[k] != lev) begin
            dba_in  = 1'b1;
            mt_we   = 1'b1;
            plev_in = lev;
         end else if (dba_ff[k] && dm <= {24'd0, db_ms_ff}) begin
            // still debouncing
         end else begin
            dba_in = 1'b0;
            case (st)
               ST_IDLE: begin
                  if (lev) begin
                     st_in = ST_PRESSED;
                     pt_we = 1'b1;
                     mt_we = 1'b1;
                     if (!raw_off && !td && !mt) begin
                        if (normal) begin
                           ev1 = 1'b1;
                           ev_word.held_ms = '0;
                        end else begin
                           seq_we = (32'(lcnt_ff) < SEQ_LEN);
                           lkd_in = 1'b1;
                        end
                     end
                  end
               end
               ST_PRESSED: begin
                  if (!lev && (td || mt)) begin
                     st_in   = ST_RELEASED;
                     mt_we   = 1'b1;
                     taps_in = 8'd1;
                  end else if (!lev) begin
                     st_in = ST_IDLE;
                     if (normal) begin
                        ev1 = 1'b1;
                        ev_word.event_kind = EV_RELEASE;
                     end else begin
                        lkd_in = 1'b0;
                     end
                  end else if (mt && dm > {16'd0, lp_ms_ff}) begin
                     st_in = ST_LONG;
                     if (!lsimple) begin
                        ev1 = 1'b1;
                        ev_word.event_kind = EV_LONG_TIMEOUT;
                     end
                  end
               end
               ST_RELEASED: begin
                  if (dm > {16'd0, tap_ms_ff}) begin
                     st_in = ST_IDLE;
                     ev1   = 1'b1;
                     ev_word.event_kind = mt ? EV_MT_SHORT : EV_TAP_DANCE;
                  end
                  if (lev) st_in = ST_TAPDANCE;
               end
               ST_LONG: begin
                  if (!lev) begin
                     st_in = ST_IDLE;
                     ev1   = 1'b1;
                     ev_word.event_kind = EV_MT_LONG;
                  end
               end
               ST_TAPDANCE: begin
                  if (!lev) begin
                     st_in = ST_RELEASED;
                     if (taps_ff != 8'hff) taps_in = taps_ff + 8'd1;
                     mt_we = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // leader run is copied into a small burst snapshot and drained one word a cycle
   logic [7:0] snap_ff [NOUT];
   logic [7:0] snap_cnt_ff;

   always_ff @(posedge clock) begin
      if (lead_fire) begin
         for (int i = 0; i < NOUT; i++) snap_ff[i] <= lseq_ff[i];
         snap_cnt_ff <= lcnt_ff;
      end
      if (reset) begin
         for (int i = 0; i < NKEYS; i++) begin
            pst_ff[i]   <= ST_IDLE;
            plev_ff[i]  <= 1'b0;
            dba_ff[i]   <= 1'b0;
            ptime_ff[i] <= '0;
            mtime_ff[i] <= '0;
         end
         for (int i = 0; i < SEQ_LEN; i++) lseq_ff[i] <= EMPTY_SLOT;
         taps_ff <= '0;
         lph_ff  <= LP_IDLE;
         ltim_ff <= '0;
         lcnt_ff <= '0;
         lkd_ff  <= 1'b0;
         larm_ff <= 1'b1;
         lead_busy_ff <= 1'b0;
         lead_idx_ff  <= '0;
      end else begin
         if (iv_ff && ir_ff.func && kok) begin
            pst_ff[k]  <= st_in;
            plev_ff[k] <= plev_in;
            dba_ff[k]  <= dba_in;
            if (pt_we) ptime_ff[k] <= now;
            if (mt_we) mtime_ff[k] <= now;
         end
         if (seq_clr) for (int i = 0; i < SEQ_LEN; i++) lseq_ff[i] <= EMPTY_SLOT;
         if (seq_we) lseq_ff[lcnt_ff[LSW-1:0]] <= {4'd0, k};
         taps_ff <= taps_in;
         lph_ff  <= lph_in;
         ltim_ff <= ltim_in;
         lcnt_ff <= lcnt_in;
         lkd_ff  <= lkd_in;
         larm_ff <= larm_in;
         if (lead_fire) begin
            lead_busy_ff <= 1'b1;
            lead_idx_ff  <= '0;
         end else if (lead_busy_ff) begin
            if (32'(lead_idx_ff) == NOUT - 1) lead_busy_ff <= 1'b0;
            lead_idx_ff <= lead_idx_ff + LIW'(1);
         end
      end
   end

   // key events and leader words never coincide: req is held off from the firing
   // tick until the burst has been written
   logic key_push;
   assign key_push = ev1 && !lead_busy_ff;

   always_comb begin
      push      = lead_busy_ff || ev1;
      push_word = ev_word;
      if (lead_busy_ff) begin
         push_word = '{event_kind: EV_LEADER, key_index_out: 4'd0, held_ms: 32'd0,
                       tap_count: snap_cnt_ff,
                       seq_key: snap_ff[lead_idx_ff],
                       last: (32'(lead_idx_ff) == NOUT - 1)};
      end
   end

   kmth_out_fifo #(.DEPTH(QDEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .free_cnt  (free_cnt),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   `ASSERT_CLK(a_no_collide, clock, reset, !(lead_busy_ff && ev1), "event during leader burst")
   `ASSERT_CLK(a_fire_idle, clock, reset, lead_fire |=> (lph_ff == LP_IDLE && !larm_ff),
      "leader fire left machine active")
   `ASSERT_CLK(a_key_push, clock, reset, key_push |-> push, "key event lost")
endmodule
`default_nettype wire

// File: rtl/core/kmth_out_fifo.sv
// Result queue between the engine and the rsp channel
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kmth_out_fifo
   import kmth_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_word,
   output logic [$clog2(DEPTH+1)-1:0] free_cnt,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_word
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   rsp_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_word  = mem_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign free_cnt  = CW'(DEPTH) - cnt_ff;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_CLK(a_no_overflow, clock, reset, push |-> (cnt_ff != CW'(DEPTH)), "fifo overflow")
   `ASSERT_CLK(a_cnt_step, clock, reset,
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + CW'(1)), "fifo count slip")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "fifo not empty after reset")
endmodule
`default_nettype wire

// File: tb/kmth_checker.sv
// Event predictor and scoreboard for the tap-hold engine
`timescale 1ns / 1ps
module kmth_checker
   import kmth_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  req_type          req_word,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  rsp_type          rsp_word,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   logic        cfg_leader_mode;
   logic [63:0] cfg_key_modes;
   logic [31:0] cfg_long_ms, cfg_tap_ms, cfg_deb_ms;

   logic [2:0]  key_state [16];
   logic        key_level_q [16];
   logic        key_bouncing [16];
   logic [31:0] key_down_at [16];
   logic [31:0] key_mark [16];
   logic [7:0]  taps;
   logic [1:0]  ldr_phase;
   logic [31:0] ldr_timer;
   logic [7:0]  ldr_seq [8];
   logic [7:0]  ldr_count;
   logic        ldr_down, ldr_armed;

   rsp_type expected_events [$];

   function automatic rsp_type key_event(logic [2:0] kind, logic [3:0] key,
                                         logic [31:0] held);
      rsp_type r;
      r.event_kind = kind;
      r.key_index_out = key;
      r.held_ms = held;
      r.tap_count = taps;
      r.seq_key = EMPTY_SLOT;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_tick(logic [31:0] now);
      rsp_type r;
      if (cfg_leader_mode && ldr_armed) begin
         case (ldr_phase)
            LP_WAIT: begin
               if (ldr_down) begin
                  ldr_phase = LP_HELD;
               end else if (now - ldr_timer > cfg_tap_ms) begin
                  for (int i = 0; i < 8; i++) begin
                     r.event_kind = EV_LEADER;
                     r.key_index_out = '0;
                     r.held_ms = '0;
                     r.tap_count = ldr_count;
                     r.seq_key = ldr_seq[i];
                     r.last = (i == 7);
                     expected_events.push_back(r);
                  end
                  ldr_armed = 1'b0;
                  ldr_phase = LP_IDLE;
               end
            end
            LP_HELD: begin
               if (!ldr_down) begin
                  if (ldr_count != 8'd255) ldr_count++;
                  ldr_timer = now;
                  ldr_phase = LP_WAIT;
               end
            end
            default: begin
               ldr_timer = now;
               ldr_phase = LP_WAIT;
               for (int i = 0; i < 8; i++) ldr_seq[i] = EMPTY_SLOT;
               ldr_count = '0;
               ldr_down = 1'b0;
            end
         endcase
      end else if (!cfg_leader_mode) begin
         ldr_armed = 1'b1;
      end
   endtask

   task automatic predict_sample(logic [3:0] key, logic lvl, logic [31:0] now);
      logic [3:0]  flags;
      logic        td, mt;
      logic [2:0]  st;
      logic [31:0] held;
      if (key_level_q[key] != lvl) begin
         key_bouncing[key] = 1'b1;
         key_mark[key] = now;
         key_level_q[key] = lvl;
         return;
      end
      if (key_bouncing[key]) begin
         if (now - key_mark[key] <= cfg_deb_ms) return;
         key_bouncing[key] = 1'b0;
      end
      flags = cfg_key_modes[4*key +: 4];
      td = flags[1];
      mt = flags[2];
      st = key_state[key];
      held = now - key_down_at[key];
      case (st)
         ST_IDLE: if (lvl) begin
            st = ST_PRESSED;
            key_down_at[key] = now;
            key_mark[key] = now;
            if (!flags[0] && !td && !mt) begin
               if (!cfg_leader_mode) begin
                  expected_events.push_back(key_event(EV_PRESS, key, '0));
               end else begin
                  if (ldr_count < 8) ldr_seq[ldr_count[2:0]] = {4'd0, key};
                  ldr_down = 1'b1;
               end
            end
         end
         ST_PRESSED: begin
            if (!lvl && (td || mt)) begin
               st = ST_RELEASED;
               key_mark[key] = now;
               taps = 8'd1;
            end else if (!lvl) begin
               st = ST_IDLE;
               if (!cfg_leader_mode)
                  expected_events.push_back(key_event(EV_RELEASE, key, held));
               else
                  ldr_down = 1'b0;
            end else if (mt && now - key_mark[key] > cfg_long_ms) begin
               st = ST_LONG;
               if (!flags[3])
                  expected_events.push_back(key_event(EV_LONG_TIMEOUT, key, held));
            end
         end
         ST_RELEASED: begin
            if (now - key_mark[key] > cfg_tap_ms) begin
               st = ST_IDLE;
               expected_events.push_back(
                  key_event(mt ? EV_MT_SHORT : EV_TAP_DANCE, key, held));
            end
            if (lvl) st = ST_TAPDANCE;
         end
         ST_LONG: if (!lvl) begin
            st = ST_IDLE;
            expected_events.push_back(key_event(EV_MT_LONG, key, held));
         end
         ST_TAPDANCE: if (!lvl) begin
            st = ST_RELEASED;
            if (taps != 8'd255) taps++;
            key_mark[key] = now;
         end
         default: ;
      endcase
      key_state[key] = st;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_leader_mode = 1'b0;
         cfg_key_modes = '0;
         cfg_long_ms = 32'(LONG_PRESS_RST);
         cfg_tap_ms = 32'(TAP_INTV_RST);
         cfg_deb_ms = 32'(DEBOUNCE_RST);
         for (int i = 0; i < 16; i++) begin
            key_state[i] = ST_IDLE;
            key_level_q[i] = 1'b0;
            key_bouncing[i] = 1'b0;
            key_down_at[i] = '0;
            key_mark[i] = '0;
         end
         for (int i = 0; i < 8; i++) ldr_seq[i] = EMPTY_SLOT;
         taps = '0;
         ldr_phase = LP_IDLE;
         ldr_timer = '0;
         ldr_count = '0;
         ldr_down = 1'b0;
         ldr_armed = 1'b1;
         expected_events.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE_SELECT: cfg_leader_mode = csr_wdata[0];
               CSR_KEY_MODES:   cfg_key_modes = csr_wdata;
               CSR_LONG_PRESS:  cfg_long_ms = {16'd0, csr_wdata[15:0]};
               CSR_TAP_INTV:    cfg_tap_ms = {16'd0, csr_wdata[15:0]};
               CSR_DEBOUNCE:    cfg_deb_ms = {24'd0, csr_wdata[7:0]};
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (!req_word.func) predict_tick(req_word.now_ms);
            else predict_sample(req_word.key_index, req_word.key_level, req_word.now_ms);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected event word %p", rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_events.pop_front();
               if (want !== rsp_word) begin
                  if (fail_count < 10)
                     $display("event mismatch: expected %p got %p", want, rsp_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_events.size();
   end
endmodule

// File: tb/key_matrix_tap_hold_engine_tb.sv
// Stimulus and verdict for the tap-hold engine
`timescale 1ns / 1ps
module key_matrix_tap_hold_engine_tb;
   import kmth_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_word;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_MODE_SELECT;
   logic [63:0] csr_wdata = '0;
   int          fail_count, pending_count;
   logic [31:0] clock_ms = 32'd1000;
   bit          hold_rsp = 1'b0;

   always #1 clock = ~clock;

   key_matrix_tap_hold_engine u_dut (.*);

   kmth_checker u_check (.*);

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if ($urandom_range(0, 1)) gap = 0;
         rsp_stall <= (gap != 0);
         repeat (gap) @(negedge clock);
      end
   end

   // offers one word; valid stays up after the accepting edge until the next call
   // replaces or drops it, or drain_events drops it
   task automatic send_word(bit f, logic [3:0] key, bit lvl, int step, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 18) : 0;
      if (gaps && $urandom_range(0, 2) == 0) gap = 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      clock_ms = clock_ms + step;
      req_word.func <= f;
      req_word.key_index <= key;
      req_word.key_level <= lvl;
      req_word.now_ms <= clock_ms;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_events();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // level change: edge, then a second sample hold ms later, past debounce time only when hold exceeds it
   task automatic settle_level(logic [3:0] key, bit lvl, int hold, bit gaps);
      send_word(1'b1, key, lvl, 1, gaps);
      send_word(1'b1, key, lvl, hold, gaps);
   endtask

   task automatic random_phase(int count, bit leader_mode);
      int k, r;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 15);
         r = $urandom_range(0, 99);
         if (r < 10) send_word(1'b0, 4'($urandom), 1'($urandom),
                               $urandom_range(0, 700), 1'b1);
         else if (r < 15) send_word(1'b1, 4'(k), 1'($urandom),
                                    $urandom_range(0, 40), 1'b1);
         else if (r < 17) send_word(1'($urandom), 4'($urandom), 1'($urandom),
                                    $urandom, 1'b1);
         else begin
            settle_level(4'(k), 1'b1, $urandom_range(0, 60) + 21, 1'b1);
            if (leader_mode) send_word(1'b0, 4'(k), 1'b0, 5, 1'b1);
            send_word(1'b1, 4'(k), 1'b1, $urandom_range(0, 900), 1'b1);
            settle_level(4'(k), 1'b0, $urandom_range(0, 60) + 21, 1'b1);
            if (leader_mode || $urandom_range(0, 3) == 0)
               send_word(1'b0, 4'(k), 1'b0, $urandom_range(0, 900), 1'b1);
            send_word(1'b1, 4'(k), 1'b0, $urandom_range(0, 900), 1'b1);
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: press/release, debounce edge, last key of the matrix, time wrap
      settle_level(4'd0, 1'b1, 21, 1'b0);
      settle_level(4'd0, 1'b0, 20, 1'b0);
      send_word(1'b1, 4'd0, 1'b0, 1, 1'b0);
      settle_level(4'd15, 1'b1, 21, 1'b0);
      clock_ms = 32'hFFFF_FFF0;
      settle_level(4'd15, 1'b0, 40, 1'b0);
      send_word(1'b0, 4'd0, 1'b0, 5, 1'b0);
      drain_events();

      // tap dance on key 1, mod tap on key 2 (long and short), simple long on 3
      csr_write(CSR_KEY_MODES, 64'hC420);
      csr_write(CSR_LONG_PRESS, 64'd100);
      csr_write(CSR_TAP_INTV, 64'd50);
      csr_write(CSR_DEBOUNCE, 64'd0);
      settle_level(4'd1, 1'b1, 1, 1'b0);
      settle_level(4'd1, 1'b0, 1, 1'b0);
      settle_level(4'd1, 1'b1, 1, 1'b0);
      settle_level(4'd1, 1'b0, 1, 1'b0);
      send_word(1'b1, 4'd1, 1'b0, 60, 1'b0);
      settle_level(4'd2, 1'b1, 1, 1'b0);
      send_word(1'b1, 4'd2, 1'b1, 200, 1'b0);
      settle_level(4'd2, 1'b0, 1, 1'b0);
      settle_level(4'd3, 1'b1, 1, 1'b0);
      send_word(1'b1, 4'd3, 1'b1, 200, 1'b0);
      settle_level(4'd3, 1'b0, 1, 1'b0);
      settle_level(4'd2, 1'b1, 1, 1'b0);
      settle_level(4'd2, 1'b0, 1, 1'b0);
      send_word(1'b1, 4'd2, 1'b1, 80, 1'b0);
      drain_events();

      // leader sequence
      csr_write(CSR_KEY_MODES, 64'h0001_0000_0000_0000);
      csr_write(CSR_MODE_SELECT, 64'd1);
      csr_write(CSR_TAP_INTV, 64'hFFFF);
      csr_write(CSR_DEBOUNCE, 64'hFF);
      random_phase(13, 1'b1);
      send_word(1'b0, 4'd0, 1'b0, 70000, 1'b0);
      send_word(1'b0, 4'd0, 1'b0, 70000, 1'b0);
      drain_events();

      // normal mode, random flags; receiver held off long
      csr_write(CSR_MODE_SELECT, 64'd0);
      csr_write(CSR_KEY_MODES, {$urandom, $urandom});
      csr_write(CSR_LONG_PRESS, 64'd300);
      csr_write(CSR_TAP_INTV, 64'd200);
      csr_write(CSR_DEBOUNCE, 64'd20);
      hold_rsp = 1'b1;
      random_phase(11, 1'b0);
      drain_events();

      csr_write(CSR_KEY_MODES, {$urandom, $urandom} & 64'h6666_6666_6666_6666);
      csr_write(CSR_LONG_PRESS, 64'hFFFF);
      csr_write(CSR_TAP_INTV, 64'd0);
      random_phase(11, 1'b0);
      drain_events();

      csr_write(CSR_MODE_SELECT, 64'd1);
      csr_write(CSR_KEY_MODES, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_LONG_PRESS, 64'd0);
      csr_write(CSR_TAP_INTV, 64'd400);
      csr_write(CSR_DEBOUNCE, 64'd0);
      random_phase(5, 1'b1);
      drain_events();
      csr_write(CSR_KEY_MODES, {$urandom, $urandom} & 64'hAAAA_AAAA_AAAA_AAAA);
      random_phase(16, 1'b1);
      drain_events();

      csr_write(CSR_MODE_SELECT, 64'd0);
      random_phase(11, 1'b0);
      drain_events();

      @(negedge clock);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/kmth_pkg.sv
rtl/core/kmth_out_fifo.sv
rtl/core/key_matrix_tap_hold_engine.sv
tb/kmth_checker.sv
tb/key_matrix_tap_hold_engine_tb.sv
